/* hdl/mmcal_pkg.sv */
// Shared widths, constants and register indexes for the magnetometer min/max calibrator.
package mmcal_pkg;

  localparam int unsigned RAW_W    = 16;             // sample and offset width
  localparam int unsigned HALF_W   = 15;             // half-range width
  localparam int unsigned SUM_W    = 17;             // sum of three half-ranges
  localparam int unsigned FRAC_W   = 24;             // Q8.24 fraction bits
  localparam int unsigned SCALE_W  = 32;             // scale factor width
  localparam int unsigned DVD_W    = SUM_W + FRAC_W; // dividend width
  localparam int unsigned DSR_W    = 27;             // divisor width, 3000 * half
  localparam int unsigned CNT_W    = $clog2(DVD_W + 1);
  localparam int unsigned DIV_K    = 3000;           // 3 axes x 1000
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TDATA_IN_W  = 48;
  localparam int unsigned TDATA_OUT_W = 152;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_SCALE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_SCALE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_SCALE_Z = 2'd2;

  localparam logic [SCALE_W-1:0] DEF_SCALE_X_RST = 32'd15421;
  localparam logic [SCALE_W-1:0] DEF_SCALE_Y_RST = 32'd15530;
  localparam logic [SCALE_W-1:0] DEF_SCALE_Z_RST = 32'd20170;

  localparam logic signed [RAW_W-1:0] MAX_RST = 16'sh8000;
  localparam logic signed [RAW_W-1:0] MIN_RST = 16'sh7FFF;

endpackage

/* hdl/mmcal_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, saturating to 32 bits.
module mmcal_div
  import mmcal_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DVD_W-1:0]   dividend_i,
  input  logic [DSR_W-1:0]   divisor_i,
  output logic               done_o,
  output logic [SCALE_W-1:0] quot_o
);

  logic [DVD_W-1:0] dvd_q, dvd_d;   // dividend shifts out, quotient shifts in
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DSR_W-1:0] dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DSR_W:0]   rem_sh;
  logic [DSR_W+1:0] sub;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    sub    = {1'b0, rem_sh} - {2'b00, dsr_q};
    ge     = ~sub[DSR_W+1];
    rem_d  = ge ? sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    dvd_d  = {dvd_q[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvd_q  <= dividend_i;
        rem_q  <= '0;
        dsr_q  <= divisor_i;
        cnt_q  <= CNT_W'(DVD_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dvd_q <= dvd_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  // saturate when the quotient needs more than 32 bits
  assign quot_o = (|dvd_q[DVD_W-1:SCALE_W]) ? '1 : dvd_q[SCALE_W-1:0];

endmodule

/* hdl/magnetometer_minmax_calibrator_unit.sv */
// Top level of the magnetometer min/max hard/soft iron calibrator.
// Each x/y/z sample word updates the running per-axis minimum and maximum and
// yields one result word: the hard-iron offsets (midpoint, truncated toward zero),
// the current Q8.24 scale factors, a scale-updated flag and a mask of axes that set
// a new extreme. Once all three half-ranges are nonzero, new scales are computed
// as floor((hx+hy+hz)*2^24 / (3000*h_axis)), saturated to 32 bits; until then the
// default scale registers are reported. One sample is processed at a time. A sample
// with a zero half-range on some axis passes through the min/max update, the offset
// and half-range step and the output hand-over; a sample that recalculates the
// scales also runs the single bit-serial divider once per axis (41 quotient bits),
// each run preceded by a divisor set-up step and a start step, before the hand-over.
// A stalled result adds the stall time. The next sample is taken while the previous
// result still waits in the output register.
// Configuration writes are always accepted; they must only be issued while idle.
module magnetometer_minmax_calibrator_unit
  import mmcal_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // sample words
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata_i,  // raw_x, raw_y, raw_z
  // result words
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata_o,  // offset_x, offset_y, offset_z,
                                                  // scale_x, scale_y, scale_z,
                                                  // scale_updated, extremes_changed,
                                                  // 4 zero bits
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SCALE_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,    // min/max update
    ST_CALC,   // offsets and half-ranges
    ST_MUL,    // divisor for current axis
    ST_LOAD,   // kick off divider
    ST_DIV,    // wait for quotient
    ST_OUT     // hand to output register
  } state_e;

  state_e state_q;

  logic signed [RAW_W-1:0]  raw_q   [3];
  logic signed [RAW_W-1:0]  max_q   [3];
  logic signed [RAW_W-1:0]  min_q   [3];
  logic signed [RAW_W-1:0]  off_q   [3];
  logic [HALF_W-1:0]        half_q  [3];
  logic [SCALE_W-1:0]       store_q [3];
  logic [SCALE_W-1:0]       def_q   [3];
  logic [SUM_W-1:0]         sum_q;
  logic [DSR_W-1:0]         dsr_q;
  logic [1:0]               axis_q;
  logic [2:0]               chg_q;
  logic                     have_q;
  logic                     upd_q;

  logic                     m_valid_q;
  logic [TDATA_OUT_W-1:0]   m_data_q;

  // combinational per-axis values
  logic signed [RAW_W-1:0]  max_d   [3];
  logic signed [RAW_W-1:0]  min_d   [3];
  logic [2:0]               chg_d;
  logic signed [RAW_W:0]    msum    [3];
  logic signed [RAW_W:0]    mrnd    [3];
  logic [RAW_W:0]           mdiff   [3];
  logic signed [RAW_W-1:0]  off_d   [3];
  logic [HALF_W-1:0]        half_d  [3];
  logic [SUM_W-1:0]         sum_d;
  logic [DSR_W-1:0]         dsr_d;
  logic [SCALE_W-1:0]       scl     [3];

  logic                     s_acc, out_free;
  logic                     div_start, div_done;
  logic [SCALE_W-1:0]       div_quot;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~m_valid_q | m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;
  assign div_start       = (state_q == ST_LOAD);

  always_comb begin
    sum_d = '0;
    for (int a = 0; a < 3; a++) begin
      // strict compares: a repeat of the current extreme is not news
      max_d[a] = (raw_q[a] > max_q[a]) ? raw_q[a] : max_q[a];
      min_d[a] = (raw_q[a] < min_q[a]) ? raw_q[a] : min_q[a];
      chg_d[a] = (raw_q[a] > max_q[a]) | (raw_q[a] < min_q[a]);
      // midpoint, truncated toward zero: bias negatives by one before the shift
      msum[a]  = {max_q[a][RAW_W-1], max_q[a]} + {min_q[a][RAW_W-1], min_q[a]};
      mrnd[a]  = msum[a] + {{RAW_W{1'b0}}, msum[a][RAW_W]};
      off_d[a] = mrnd[a][RAW_W:1];
      // max >= min once a sample has been seen
      mdiff[a]  = {max_q[a][RAW_W-1], max_q[a]} - {min_q[a][RAW_W-1], min_q[a]};
      half_d[a] = mdiff[a][HALF_W:1];
      sum_d     = sum_d + SUM_W'(half_d[a]);
      scl[a]    = have_q ? store_q[a] : def_q[a];
    end
    dsr_d = DSR_W'(half_q[axis_q]) * DSR_W'(DIV_K);
  end

  mmcal_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_q, {FRAC_W{1'b0}}}),
    .divisor_i  (dsr_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      axis_q    <= '0;
      chg_q     <= '0;
      have_q    <= 1'b0;
      upd_q     <= 1'b0;
      sum_q     <= '0;
      dsr_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      def_q[0]  <= DEF_SCALE_X_RST;
      def_q[1]  <= DEF_SCALE_Y_RST;
      def_q[2]  <= DEF_SCALE_Z_RST;
      for (int a = 0; a < 3; a++) begin
        raw_q[a]   <= '0;
        max_q[a]   <= MAX_RST;
        min_q[a]   <= MIN_RST;
        off_q[a]   <= '0;
        half_q[a]  <= '0;
        store_q[a] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_DEF_SCALE_X: def_q[0] <= cfg_data_i;
          CFG_DEF_SCALE_Y: def_q[1] <= cfg_data_i;
          CFG_DEF_SCALE_Z: def_q[2] <= cfg_data_i;
          default: ;  // unknown index, ignored
        endcase
      end

      // in ST_OUT the output register is reloaded below instead
      if (m_valid_q && m_axis_tready_i && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            raw_q[0] <= s_axis_tdata_i[15:0];
            raw_q[1] <= s_axis_tdata_i[31:16];
            raw_q[2] <= s_axis_tdata_i[47:32];
            state_q  <= ST_UPD;
          end
        end
        ST_UPD: begin
          for (int a = 0; a < 3; a++) begin
            max_q[a] <= max_d[a];
            min_q[a] <= min_d[a];
          end
          chg_q   <= chg_d;
          upd_q   <= 1'b0;
          state_q <= ST_CALC;
        end
        ST_CALC: begin
          for (int a = 0; a < 3; a++) begin
            off_q[a]  <= off_d[a];
            half_q[a] <= half_d[a];
          end
          sum_q  <= sum_d;
          axis_q <= '0;
          if ((half_d[0] != '0) && (half_d[1] != '0) && (half_d[2] != '0)) begin
            state_q <= ST_MUL;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_MUL: begin
          dsr_q   <= dsr_d;
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            store_q[axis_q] <= div_quot;
            if (axis_q == 2'd2) begin
              have_q  <= 1'b1;
              upd_q   <= 1'b1;
              state_q <= ST_OUT;
            end else begin
              axis_q  <= axis_q + 1'b1;
              state_q <= ST_MUL;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {4'b0000, chg_q, upd_q, scl[2], scl[1], scl[0],
                          off_q[2], off_q[1], off_q[0]};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

/* hdl/mmcal_checker.sv */
// Port-level checks for the calibrator, bound to the top level.
module mmcal_checker
  import mmcal_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [TDATA_OUT_W-1:0] m_axis_tdata_o
);

  // result word held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // one sample in flight: no back-to-back acceptance
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("sample accepted while another is in flight");

  // a freshly computed scale is never zero
  a_scale_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[144] |->
      (m_axis_tdata_o[79:48] != '0) && (m_axis_tdata_o[111:80] != '0) &&
      (m_axis_tdata_o[143:112] != '0))
    else $error("updated scale is zero");

  // pad bits stay clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[151:148] == 4'b0000))
    else $error("pad bits set in result word");

endmodule

bind magnetometer_minmax_calibrator_unit mmcal_checker u_mmcal_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
